@@ rtl/dtca_pkg.sv @@
// Shared types, constants and the sequencer program for the dual temperature averager.
`timescale 1ns / 1ps

package dtca_pkg;

  // Field and register widths
  localparam int RAW_W    = 20;
  localparam int CAL_W    = 16;
  localparam int TEMP_W   = 15;
  localparam int FINE_W   = 32;
  localparam int CNT_W    = 7;
  localparam int SUM_W    = 21;
  localparam int CFG_IDX_W = 3;

  // Session length default
  localparam int SESSION_LENGTH_DEF = 120;

  // Reciprocal scaling for the session mean divide
  localparam int DIV_SHIFT = 20;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 22;
  localparam int PROD_W = 2 * MUL_W;

  // Temperature limits, hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 15'sd8500;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_T1_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T2_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T3_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T1_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T2_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_T3_B = 3'd5;

  // Program counter width
  localparam int PC_W = 4;

  // Multiplier operand selects
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_V1   = 3'd1;  // ((raw>>3) - 2*T1) * T2
  localparam logic [2:0] MUL_DD   = 3'd2;  // d * d
  localparam logic [2:0] MUL_V2   = 3'd3;  // ((d*d)>>12) * T3
  localparam logic [2:0] MUL_QEST = 3'd4;  // |sum| * reciprocal
  localparam logic [2:0] MUL_QL   = 3'd5;  // quotient estimate * length

  // Datapath actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_LOAD = 3'd1;
  localparam logic [2:0] ACT_VAR1 = 3'd2;
  localparam logic [2:0] ACT_FINE = 3'd3;
  localparam logic [2:0] ACT_PAIR = 3'd4;
  localparam logic [2:0] ACT_QEST = 3'd5;
  localparam logic [2:0] ACT_CORR = 3'd6;
  localparam logic [2:0] ACT_OUT  = 3'd7;

  // Jump kinds
  localparam logic [1:0] JMP_NEXT    = 2'd0;
  localparam logic [1:0] JMP_GOTO    = 2'd1;
  localparam logic [1:0] JMP_IF_MORE = 2'd2;  // go to target unless the session ends

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_OUT  = 4'd14;

  // One control word of the program
  typedef struct packed {
    logic            in_wait;
    logic            out_wait;
    logic            sensor;
    logic [2:0]      mul_op;
    logic [2:0]      act;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } uc_word_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic       sensor;
    logic [2:0] mul_op;
    logic [2:0] act;
  } dtca_ctl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic last;
  } dtca_sts_t;

  // Program store
  function automatic uc_word_t uc_rom(input logic [PC_W-1:0] pc);
    uc_word_t w;
    w = '0;
    w.mul_op = MUL_NONE;
    w.act    = ACT_NONE;
    w.jmp    = JMP_NEXT;
    w.target = PC_IDLE;
    case (pc)
      4'd0: begin
        w.in_wait = 1'b1;
        w.act     = ACT_LOAD;
      end
      4'd1: w.mul_op = MUL_V1;
      4'd2: begin
        w.act    = ACT_VAR1;
        w.mul_op = MUL_DD;
      end
      4'd3: w.mul_op = MUL_V2;
      4'd4: w.act = ACT_FINE;
      4'd5: begin
        w.sensor = 1'b1;
        w.mul_op = MUL_V1;
      end
      4'd6: begin
        w.sensor = 1'b1;
        w.act    = ACT_VAR1;
        w.mul_op = MUL_DD;
      end
      4'd7: begin
        w.sensor = 1'b1;
        w.mul_op = MUL_V2;
      end
      4'd8: begin
        w.sensor = 1'b1;
        w.act    = ACT_FINE;
      end
      4'd9: begin
        w.act    = ACT_PAIR;
        w.jmp    = JMP_IF_MORE;
        w.target = PC_OUT;
      end
      4'd10: w.mul_op = MUL_QEST;
      4'd11: w.act = ACT_QEST;
      4'd12: w.mul_op = MUL_QL;
      4'd13: w.act = ACT_CORR;
      4'd14: begin
        w.out_wait = 1'b1;
        w.act      = ACT_OUT;
        w.jmp      = JMP_GOTO;
        w.target   = PC_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/dtca_sequencer.sv @@
// Microcode sequencer: step counter, program store, wait and jump logic.
`timescale 1ns / 1ps

module dtca_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dtca_pkg::dtca_sts_t  sts,
  output dtca_pkg::dtca_ctl_t  ctl
);

  logic [dtca_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dtca_pkg::uc_word_t        uc;
  logic                      slot_free;
  logic                      exec;

  assign uc        = dtca_pkg::uc_rom(pc_r);
  assign slot_free = !out_valid_r || out_ready;

  // A waiting step runs only once its condition holds
  always_comb begin
    if (uc.in_wait) begin
      exec = in_valid;
    end else if (uc.out_wait) begin
      exec = slot_free;
    end else begin
      exec = 1'b1;
    end
  end

  assign in_ready   = uc.in_wait;
  assign ctl.sensor = uc.sensor;
  assign ctl.mul_op = exec ? uc.mul_op : dtca_pkg::MUL_NONE;
  assign ctl.act    = exec ? uc.act : dtca_pkg::ACT_NONE;

  // Next step
  always_comb begin
    pc_nxt = pc_r;
    if (exec) begin
      case (uc.jmp)
        dtca_pkg::JMP_NEXT:    pc_nxt = pc_r + 1'b1;
        dtca_pkg::JMP_GOTO:    pc_nxt = uc.target;
        dtca_pkg::JMP_IF_MORE: pc_nxt = sts.last ? pc_r + 1'b1 : uc.target;
        default:               pc_nxt = dtca_pkg::PC_IDLE;
      endcase
    end
  end

  // Result slot occupancy
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (exec && uc.act == dtca_pkg::ACT_OUT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= dtca_pkg::PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/dtca_datapath.sv @@
// Datapath: calibration registers, shared multiplier, working registers and result register.
`timescale 1ns / 1ps

module dtca_datapath #(
  parameter int SESSION_LENGTH = dtca_pkg::SESSION_LENGTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dtca_pkg::dtca_ctl_t                   ctl,
  output dtca_pkg::dtca_sts_t                   sts,
  input  logic                                  cfg_we,
  input  logic [dtca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dtca_pkg::CAL_W-1:0]            cfg_data,
  input  logic [dtca_pkg::RAW_W-1:0]            raw_a,
  input  logic [dtca_pkg::RAW_W-1:0]            raw_b,
  output logic signed [dtca_pkg::TEMP_W-1:0]    temp_a,
  output logic signed [dtca_pkg::TEMP_W-1:0]    temp_b,
  output logic signed [dtca_pkg::FINE_W-1:0]    fine_a,
  output logic signed [dtca_pkg::FINE_W-1:0]    fine_b,
  output logic signed [dtca_pkg::TEMP_W-1:0]    pair_mean,
  output logic signed [dtca_pkg::TEMP_W-1:0]    session_mean,
  output logic                                  session_done
);

  localparam int QW = dtca_pkg::DIV_SHIFT + 1;
  localparam logic [QW-1:0] RECIP = QW'((1 << dtca_pkg::DIV_SHIFT) / SESSION_LENGTH);
  localparam logic [dtca_pkg::CNT_W-1:0] LEN = dtca_pkg::CNT_W'(SESSION_LENGTH);
  localparam logic [dtca_pkg::CNT_W-1:0] LEN_M1 = dtca_pkg::CNT_W'(SESSION_LENGTH - 1);
  localparam int TF_W = 25;

  // Calibration registers
  logic [dtca_pkg::CAL_W-1:0] t1_a_r, t2_a_r, t3_a_r, t1_b_r, t2_b_r, t3_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_a_r <= '0;
      t2_a_r <= '0;
      t3_a_r <= '0;
      t1_b_r <= '0;
      t2_b_r <= '0;
      t3_b_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtca_pkg::REG_T1_A: t1_a_r <= cfg_data;
        dtca_pkg::REG_T2_A: t2_a_r <= cfg_data;
        dtca_pkg::REG_T3_A: t3_a_r <= cfg_data;
        dtca_pkg::REG_T1_B: t1_b_r <= cfg_data;
        dtca_pkg::REG_T2_B: t2_b_r <= cfg_data;
        dtca_pkg::REG_T3_B: t3_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working registers
  logic [dtca_pkg::RAW_W-1:0]               raw_a_r, raw_b_r;
  logic signed [dtca_pkg::PROD_W-1:0]       p_r;
  logic signed [22:0]                       var1_r;
  logic signed [dtca_pkg::TEMP_W-1:0]       ta_r, tb_r, pm_r, sm_r;
  logic signed [TF_W-1:0]                   tfa_r, tfb_r;
  logic                                     done_r;
  logic [dtca_pkg::CNT_W-1:0]               count_r;
  logic signed [dtca_pkg::SUM_W-1:0]        sum_r;
  logic [QW-1:0]                            abs_r, q_r;
  logic                                     neg_r;

  // Operands of the selected sensor
  logic [dtca_pkg::RAW_W-1:0] adc;
  logic [dtca_pkg::CAL_W-1:0] t1, t2, t3;

  assign adc = ctl.sensor ? raw_b_r : raw_a_r;
  assign t1  = ctl.sensor ? t1_b_r : t1_a_r;
  assign t2  = ctl.sensor ? t2_b_r : t2_a_r;
  assign t3  = ctl.sensor ? t3_b_r : t3_a_r;

  logic signed [17:0] v1_in;
  logic signed [16:0] d;

  assign v1_in = $signed({1'b0, adc[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d     = $signed({1'b0, adc[19:4]}) - $signed({1'b0, t1});

  // Multiplier operand select
  logic signed [dtca_pkg::MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_op)
      dtca_pkg::MUL_V1: begin
        mul_a = dtca_pkg::MUL_W'(v1_in);
        mul_b = dtca_pkg::MUL_W'($signed(t2));
      end
      dtca_pkg::MUL_DD: begin
        mul_a = dtca_pkg::MUL_W'(d);
        mul_b = dtca_pkg::MUL_W'(d);
      end
      dtca_pkg::MUL_V2: begin
        mul_a = $signed({1'b0, p_r[32:12]});
        mul_b = dtca_pkg::MUL_W'($signed(t3));
      end
      dtca_pkg::MUL_QEST: begin
        mul_a = $signed({1'b0, abs_r});
        mul_b = $signed({1'b0, RECIP});
      end
      dtca_pkg::MUL_QL: begin
        mul_a = $signed({1'b0, q_r});
        mul_b = $signed({{(dtca_pkg::MUL_W - dtca_pkg::CNT_W){1'b0}}, LEN});
      end
      default: ;
    endcase
  end

  // Fine temperature and saturated temperature
  logic signed [TF_W-1:0] tf;
  logic signed [27:0]     t5;
  logic signed [19:0]     tsh;
  logic signed [dtca_pkg::TEMP_W-1:0] tsat;

  assign tf  = TF_W'(var1_r) + TF_W'($signed(p_r[36:14]));
  assign t5  = (28'(tf) <<< 2) + 28'(tf) + 28'sd128;
  assign tsh = t5[27:8];

  always_comb begin
    if (tsh < dtca_pkg::TEMP_MIN) begin
      tsat = dtca_pkg::TEMP_MIN;
    end else if (tsh > dtca_pkg::TEMP_MAX) begin
      tsat = dtca_pkg::TEMP_MAX;
    end else begin
      tsat = tsh[dtca_pkg::TEMP_W-1:0];
    end
  end

  // Pair mean and session bookkeeping
  logic signed [15:0]                 pair_sum;
  logic signed [dtca_pkg::TEMP_W-1:0] pm;
  logic signed [dtca_pkg::SUM_W-1:0]  sum_new;
  logic [QW-1:0]                      rem;
  logic [QW-1:0]                      q_fin;
  logic [QW-1:0]                      q_sgn;

  assign pair_sum = 16'(ta_r) + 16'(tb_r);
  assign pm       = pair_sum[15:1];
  assign sum_new  = sum_r + dtca_pkg::SUM_W'(pm);
  assign sts.last = (count_r >= LEN_M1);

  // Remainder check corrects the reciprocal estimate by at most one
  assign rem   = abs_r - p_r[QW-1:0];
  assign q_fin = (rem >= QW'(LEN)) ? q_r + 1'b1 : q_r;
  assign q_sgn = neg_r ? -q_fin : q_fin;

  // Control state of the session
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (ctl.act == dtca_pkg::ACT_PAIR) begin
      if (sts.last) begin
        count_r <= '0;
        sum_r   <= '0;
      end else begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.mul_op != dtca_pkg::MUL_NONE) begin
      p_r <= mul_a * mul_b;
    end
    case (ctl.act)
      dtca_pkg::ACT_LOAD: begin
        raw_a_r <= raw_a;
        raw_b_r <= raw_b;
      end
      dtca_pkg::ACT_VAR1: var1_r <= p_r[33:11];
      dtca_pkg::ACT_FINE: begin
        if (ctl.sensor) begin
          tb_r  <= tsat;
          tfb_r <= tf;
        end else begin
          ta_r  <= tsat;
          tfa_r <= tf;
        end
      end
      dtca_pkg::ACT_PAIR: begin
        pm_r   <= pm;
        done_r <= sts.last;
        sm_r   <= '0;
        neg_r  <= sum_new[dtca_pkg::SUM_W-1];
        abs_r  <= sum_new[dtca_pkg::SUM_W-1] ? QW'(-sum_new) : QW'(sum_new);
      end
      dtca_pkg::ACT_QEST: q_r <= p_r[dtca_pkg::DIV_SHIFT + QW - 1:dtca_pkg::DIV_SHIFT];
      dtca_pkg::ACT_CORR: sm_r <= q_sgn[dtca_pkg::TEMP_W-1:0];
      dtca_pkg::ACT_OUT: begin
        temp_a       <= ta_r;
        temp_b       <= tb_r;
        fine_a       <= dtca_pkg::FINE_W'(tfa_r);
        fine_b       <= dtca_pkg::FINE_W'(tfb_r);
        pair_mean    <= pm_r;
        session_mean <= sm_r;
        session_done <= done_r;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/dual_temp_compensate_average_top.sv @@
// Top level: dual sensor temperature compensation, pair mean and session mean.
// The microcode program runs both sensors and the mean divide through one shared multiplier,
// and takes a new pair only after the program has returned to its idle step.
// A finished result waits in the output register while the next pair is taken.
// Reset (rst_n low, synchronous) clears calibration words, pair count, running sum
// and the result valid flag, and puts the sequencer at its idle step.
`timescale 1ns / 1ps

module dual_temp_compensate_average_top #(
  parameter int SESSION_LENGTH = dtca_pkg::SESSION_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dtca_pkg::RAW_W-1:0]          in_raw_a,
  input  logic [dtca_pkg::RAW_W-1:0]          in_raw_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dtca_pkg::TEMP_W-1:0]  out_temp_a,
  output logic signed [dtca_pkg::TEMP_W-1:0]  out_temp_b,
  output logic signed [dtca_pkg::FINE_W-1:0]  out_fine_a,
  output logic signed [dtca_pkg::FINE_W-1:0]  out_fine_b,
  output logic signed [dtca_pkg::TEMP_W-1:0]  out_pair_mean,
  output logic signed [dtca_pkg::TEMP_W-1:0]  out_session_mean,
  output logic                                out_session_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtca_pkg::CAL_W-1:0]          cfg_data
);

  dtca_pkg::dtca_ctl_t ctl;
  dtca_pkg::dtca_sts_t sts;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  dtca_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  dtca_datapath #(
    .SESSION_LENGTH (SESSION_LENGTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .raw_a        (in_raw_a),
    .raw_b        (in_raw_b),
    .temp_a       (out_temp_a),
    .temp_b       (out_temp_b),
    .fine_a       (out_fine_a),
    .fine_b       (out_fine_b),
    .pair_mean    (out_pair_mean),
    .session_mean (out_session_mean),
    .session_done (out_session_done)
  );

endmodule

@@ rtl/dtca_checker.sv @@
// Port-level checker for the dual temperature averager, bound to the top level.
`timescale 1ns / 1ps

module dtca_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dtca_pkg::TEMP_W-1:0]  out_temp_a,
  input logic signed [dtca_pkg::TEMP_W-1:0]  out_temp_b,
  input logic signed [dtca_pkg::TEMP_W-1:0]  out_pair_mean,
  input logic signed [dtca_pkg::TEMP_W-1:0]  out_session_mean,
  input logic                                out_session_done
);

  logic signed [15:0] chk_sum;

  assign chk_sum = 16'(out_temp_a) + 16'(out_temp_b);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pair_mean))
    else $error("result changed while stalled");

  // Temperatures stay within the saturation limits
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_a >= dtca_pkg::TEMP_MIN && out_temp_a <= dtca_pkg::TEMP_MAX &&
                  out_temp_b >= dtca_pkg::TEMP_MIN && out_temp_b <= dtca_pkg::TEMP_MAX)
    else $error("temperature out of range");

  // Pair mean is the floor of half the two temperatures
  a_pair_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pair_mean == chk_sum[15:1])
    else $error("pair mean mismatch");

  // Session mean reads zero outside the session's last pair
  a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_session_done |-> out_session_mean == '0)
    else $error("session mean nonzero without done");

  // Reset drops the result valid
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dual_temp_compensate_average_top dtca_checker u_dtca_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_temp_a       (out_temp_a),
  .out_temp_b       (out_temp_b),
  .out_pair_mean    (out_pair_mean),
  .out_session_mean (out_session_mean),
  .out_session_done (out_session_done)
);
